@@ sv/pfc_pkg.sv @@
package pfc_pkg;

  // Table geometry
  localparam int unsigned TABLE_SIZE = 65536;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned WIDE_W     = ((IDX_W > FIELD_W) ? IDX_W : FIELD_W) + 1;
  localparam int unsigned SQ_W       = IDX_W + 1;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SUM_W      = 40;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_BUILD = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } pfc_cmd_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_INIT,
    S_SCHK,
    S_SPRM,
    S_JRD,
    S_JCHK,
    S_ARD,
    S_AFAC,
    S_CRD,
    S_CINC,
    S_DIVS,
    S_DIVW,
    S_QRD,
    S_QACC
  } pfc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic i_zero;
    logic clr_wr;
    logic init_wr;
    logic i_inc;
    logic sieve_start;
    logic i_next;
    logic ft_rd_i;
    logic ft_rd_j;
    logic ft_rd_x;
    logic j_load;
    logic j_wr;
    logic j_inc;
    logic p_load;
    logic cnt_rd_p;
    logic cnt_inc_wr;
    logic div_start;
    logic x_load;
    logic cnt_rd_i;
    logic q_acc;
    logic set_built;
    logic out_fire;
    logic out_zero;
  } pfc_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic i_last;
    logic sq_done;
    logic is_prime;
    logic j_done;
    logic p_small;
    logic p_new;
    logic div_done;
    logic x_small;
    logic q_last;
    logic add_ok;
    logic q_empty;
  } pfc_stat_t;

endpackage

@@ sv/pfc_div.sv @@
// Restoring divider, one quotient bit per cycle.
module pfc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pfc_pkg::IDX_W-1:0] dividend,
  input  logic [pfc_pkg::IDX_W-1:0] divisor,
  output logic                      done,
  output logic [pfc_pkg::IDX_W-1:0] quotient
);

  localparam int unsigned W  = pfc_pkg::IDX_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W:0]    rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  logic [W:0]    shifted;
  logic          ge;

  assign shifted = {rem_r[W-1:0], quo_r[W-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= ge ? (shifted - {1'b0, dvs_r}) : shifted;
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ sv/pfc_dp.sv @@
// Datapath: factor table, count table, counters, divider, accumulator.
module pfc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pfc_pkg::pfc_ctl_t           ctl,
  output pfc_pkg::pfc_stat_t          stat,
  input  logic [pfc_pkg::FIELD_W-1:0] in_value,
  input  logic [pfc_pkg::FIELD_W-1:0] in_range_low,
  input  logic [pfc_pkg::FIELD_W-1:0] in_range_high,
  output logic                        out_valid,
  output logic [pfc_pkg::SUM_W-1:0]   out_count_sum
);

  localparam int unsigned IW = pfc_pkg::IDX_W;
  localparam int unsigned WW = pfc_pkg::WIDE_W;
  localparam int unsigned FW = pfc_pkg::FIELD_W;
  localparam int unsigned QW = pfc_pkg::SQ_W;
  localparam int unsigned CW = pfc_pkg::CNT_W;
  localparam int unsigned SW = pfc_pkg::SUM_W;

  logic [IW-1:0] ft_mem  [pfc_pkg::TABLE_SIZE];
  logic [CW-1:0] cnt_mem [pfc_pkg::TABLE_SIZE];

  logic [IW-1:0] i_r;
  logic [QW-1:0] sq_r;
  logic [QW-1:0] j_r;
  logic [IW-1:0] x_r;
  logic [IW-1:0] p_r;
  logic [IW-1:0] last_r;
  logic [IW-1:0] hi_r;
  logic [SW-1:0] sum_r;
  logic          built_r;
  logic          out_valid_r;
  logic [IW-1:0] ft_rd_r;
  logic [CW-1:0] cnt_rd_r;

  logic [SW-1:0] sum_nxt;
  logic [SW:0]   sum_add;
  logic [WW-1:0] val_ext;
  logic [WW-1:0] lo_ext;
  logic [WW-1:0] hi_ext;
  logic [WW-1:0] hi_clamp;
  logic [IW-1:0] init_val;
  logic [IW-1:0] ft_raddr;
  logic [IW-1:0] cnt_raddr;
  logic [CW-1:0] cnt_inc;
  logic          j_match;
  logic          div_done;
  logic [IW-1:0] div_quo;

  // ---- input checks ----
  assign val_ext  = {{(WW-FW){1'b0}}, in_value};
  assign lo_ext   = {{(WW-FW){1'b0}}, in_range_low};
  assign hi_ext   = {{(WW-FW){1'b0}}, in_range_high};
  assign hi_clamp = (hi_ext > WW'(pfc_pkg::TABLE_SIZE - 1)) ?
                    WW'(pfc_pkg::TABLE_SIZE - 1) : hi_ext;

  // ---- sieve init: even entries from 4 get 2, the rest their own index ----
  assign init_val = ((i_r >= IW'(4)) && !i_r[0]) ? IW'(2) : i_r;

  assign ft_raddr  = ctl.ft_rd_j ? j_r[IW-1:0] : (ctl.ft_rd_x ? x_r : i_r);
  assign cnt_raddr = ctl.cnt_rd_p ? p_r : i_r;
  assign j_match   = (ft_rd_r == j_r[IW-1:0]);
  assign cnt_inc   = (cnt_rd_r == pfc_pkg::COUNT_MAX) ? cnt_rd_r : cnt_rd_r + CW'(1);

  // saturating accumulate; sticky once at max
  assign sum_add = {1'b0, sum_r} + {{(SW+1-CW){1'b0}}, cnt_rd_r};
  assign sum_nxt = sum_add[SW] ? pfc_pkg::SUM_MAX : sum_add[SW-1:0];

  // ---- memories ----
  always_ff @(posedge clk) begin
    if (ctl.init_wr) begin
      ft_mem[i_r] <= init_val;
    end else if (ctl.j_wr && j_match) begin
      ft_mem[j_r[IW-1:0]] <= i_r;
    end
    if (ctl.ft_rd_i || ctl.ft_rd_j || ctl.ft_rd_x) begin
      ft_rd_r <= ft_mem[ft_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_wr || ctl.init_wr) begin
      cnt_mem[i_r] <= '0;
    end else if (ctl.cnt_inc_wr) begin
      cnt_mem[p_r] <= cnt_inc;
    end
    if (ctl.cnt_rd_p || ctl.cnt_rd_i) begin
      cnt_rd_r <= cnt_mem[cnt_raddr];
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.out_fire || ctl.out_zero;
      if (ctl.set_built) begin
        built_r <= 1'b1;
      end
      if (ctl.i_zero) begin
        i_r <= '0;
      end else if (ctl.accept) begin
        i_r <= lo_ext[IW-1:0];
      end else if (ctl.sieve_start) begin
        i_r <= IW'(3);
      end else if (ctl.i_inc || ctl.i_next) begin
        i_r <= i_r + IW'(1);
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (ctl.sieve_start) begin
      sq_r <= QW'(9);
    end else if (ctl.i_next) begin
      sq_r <= sq_r + {i_r, 1'b1};
    end
    if (ctl.j_load) begin
      j_r <= sq_r;
    end else if (ctl.j_inc) begin
      j_r <= j_r + {1'b0, i_r};
    end
    if (ctl.accept) begin
      x_r    <= val_ext[IW-1:0];
      last_r <= '0;
      hi_r   <= hi_clamp[IW-1:0];
      sum_r  <= '0;
    end else begin
      if (ctl.x_load) begin
        x_r <= div_quo;
      end
      if (ctl.p_load) begin
        p_r    <= ft_rd_r;
        last_r <= ft_rd_r;
      end
      if (ctl.q_acc) begin
        sum_r <= sum_nxt;
      end
    end
  end

  pfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (x_r),
    .divisor  (p_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---- status ----
  assign stat.i_last   = (i_r == IW'(pfc_pkg::TABLE_SIZE - 1));
  assign stat.sq_done  = (sq_r >= QW'(pfc_pkg::TABLE_SIZE));
  assign stat.is_prime = (ft_rd_r == i_r);
  assign stat.j_done   = (j_r >= QW'(pfc_pkg::TABLE_SIZE));
  assign stat.p_small  = (ft_rd_r < IW'(2));
  assign stat.p_new    = (ft_rd_r != last_r);
  assign stat.div_done = div_done;
  assign stat.x_small  = (div_quo < IW'(2));
  assign stat.q_last   = (i_r == hi_r);
  assign stat.add_ok   = built_r && (val_ext >= WW'(2)) &&
                         (val_ext < WW'(pfc_pkg::TABLE_SIZE));
  assign stat.q_empty  = (lo_ext > hi_clamp);

  assign out_valid     = out_valid_r;
  assign out_count_sum = sum_r;

endmodule

@@ sv/pfc_ctrl.sv @@
// Sequencer for clear, build, add and query.
module pfc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_cmd,
  input  pfc_pkg::pfc_stat_t stat,
  output pfc_pkg::pfc_ctl_t  ctl,
  output logic               busy
);

  pfc_pkg::pfc_state_t state_r;
  pfc_pkg::pfc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfc_pkg::S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfc_pkg::S_CLR: begin
        if (stat.i_last) state_nxt = pfc_pkg::S_IDLE;
      end
      pfc_pkg::S_IDLE: begin
        if (start) begin
          unique case (in_cmd)
            pfc_pkg::CMD_BUILD: state_nxt = pfc_pkg::S_INIT;
            pfc_pkg::CMD_ADD: begin
              if (stat.add_ok) state_nxt = pfc_pkg::S_ARD;
            end
            pfc_pkg::CMD_QUERY: begin
              if (!stat.q_empty) state_nxt = pfc_pkg::S_QRD;
            end
            default: state_nxt = pfc_pkg::S_IDLE;
          endcase
        end
      end
      pfc_pkg::S_INIT: begin
        if (stat.i_last) state_nxt = pfc_pkg::S_SCHK;
      end
      pfc_pkg::S_SCHK: begin
        state_nxt = stat.sq_done ? pfc_pkg::S_IDLE : pfc_pkg::S_SPRM;
      end
      pfc_pkg::S_SPRM: begin
        state_nxt = stat.is_prime ? pfc_pkg::S_JRD : pfc_pkg::S_SCHK;
      end
      pfc_pkg::S_JRD: begin
        state_nxt = stat.j_done ? pfc_pkg::S_SCHK : pfc_pkg::S_JCHK;
      end
      pfc_pkg::S_JCHK: state_nxt = pfc_pkg::S_JRD;
      pfc_pkg::S_ARD:  state_nxt = pfc_pkg::S_AFAC;
      pfc_pkg::S_AFAC: begin
        if (stat.p_small)    state_nxt = pfc_pkg::S_IDLE;
        else if (stat.p_new) state_nxt = pfc_pkg::S_CRD;
        else                 state_nxt = pfc_pkg::S_DIVS;
      end
      pfc_pkg::S_CRD:  state_nxt = pfc_pkg::S_CINC;
      pfc_pkg::S_CINC: state_nxt = pfc_pkg::S_DIVS;
      pfc_pkg::S_DIVS: state_nxt = pfc_pkg::S_DIVW;
      pfc_pkg::S_DIVW: begin
        if (stat.div_done) begin
          state_nxt = stat.x_small ? pfc_pkg::S_IDLE : pfc_pkg::S_ARD;
        end
      end
      pfc_pkg::S_QRD:  state_nxt = pfc_pkg::S_QACC;
      pfc_pkg::S_QACC: begin
        state_nxt = stat.q_last ? pfc_pkg::S_IDLE : pfc_pkg::S_QRD;
      end
      default: state_nxt = pfc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state_r)
      pfc_pkg::S_CLR: begin
        ctl.clr_wr = 1'b1;
        ctl.i_inc  = 1'b1;
      end
      pfc_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.accept = 1'b1;
          unique case (in_cmd)
            pfc_pkg::CMD_BUILD: ctl.i_zero = 1'b1;
            pfc_pkg::CMD_QUERY: ctl.out_zero = stat.q_empty;
            default: ctl.i_zero = 1'b0;
          endcase
        end
      end
      pfc_pkg::S_INIT: begin
        ctl.init_wr     = 1'b1;
        ctl.i_inc       = !stat.i_last;
        ctl.sieve_start = stat.i_last;
      end
      pfc_pkg::S_SCHK: begin
        ctl.set_built = stat.sq_done;
        ctl.ft_rd_i   = !stat.sq_done;
      end
      pfc_pkg::S_SPRM: begin
        ctl.j_load = stat.is_prime;
        ctl.i_next = !stat.is_prime;
      end
      pfc_pkg::S_JRD: begin
        ctl.i_next  = stat.j_done;
        ctl.ft_rd_j = !stat.j_done;
      end
      pfc_pkg::S_JCHK: begin
        ctl.j_wr  = 1'b1;
        ctl.j_inc = 1'b1;
      end
      pfc_pkg::S_ARD:  ctl.ft_rd_x = 1'b1;
      pfc_pkg::S_AFAC: ctl.p_load = !stat.p_small;
      pfc_pkg::S_CRD:  ctl.cnt_rd_p = 1'b1;
      pfc_pkg::S_CINC: ctl.cnt_inc_wr = 1'b1;
      pfc_pkg::S_DIVS: ctl.div_start = 1'b1;
      pfc_pkg::S_DIVW: ctl.x_load = stat.div_done;
      pfc_pkg::S_QRD:  ctl.cnt_rd_i = 1'b1;
      pfc_pkg::S_QACC: begin
        ctl.q_acc    = 1'b1;
        ctl.out_fire = stat.q_last;
        ctl.i_inc    = !stat.q_last;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

@@ sv/prime_factor_count_range_query.sv @@
// Prime factor counter with range queries. After reset the block is busy while
// it zeroes all TABLE_SIZE (65536) entries of the count table; start is taken
// only when busy is low. There is no way to stall the result side: a query
// answer appears on out_count_sum for exactly one cycle with out_valid high,
// and the receiver must take it then. Build and add beats produce nothing on
// the output. An add issued before the first build is dropped.
//
// Steps per beat (busy high after the accepting edge):
//   build : seeds every factor table entry and zeroes every count, then
//           runs the sieve: each candidate from 3 whose square is below
//           TABLE_SIZE is read from the factor table, and for each prime
//           every multiple from its square up is read and, if still
//           unmarked, written with that prime.
//   add   : per prime factor step, a factor table read, a count read and
//           saturating update (new prime only), then a bit-serial division
//           of the value by that factor; at most IDX_W steps.
//   query : each entry from low to high is read from the count table
//           through its registered read and added to the sum. An empty range
//           answers on the cycle after the accepting edge without going busy.
//
// Structure: pfc_ctrl sequences everything; pfc_dp holds both tables, the
// walk counters, the serial divider and the saturating 40-bit accumulator.
module prime_factor_count_range_query (
  input  logic                        clk,
  input  logic                        rst_n,
  // request beat
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_cmd,
  input  logic [pfc_pkg::FIELD_W-1:0] in_value,
  input  logic [pfc_pkg::FIELD_W-1:0] in_range_low,
  input  logic [pfc_pkg::FIELD_W-1:0] in_range_high,
  // result beat, one-cycle strobe
  output logic                        out_valid,
  output logic [pfc_pkg::SUM_W-1:0]   out_count_sum
);

  pfc_pkg::pfc_ctl_t  ctl;
  pfc_pkg::pfc_stat_t stat;

  // controller: owns the state machine and the busy flag
  pfc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .ctl    (ctl),
    .busy   (busy)
  );

  // datapath: tables, counters, divider, accumulator, output register
  pfc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .stat          (stat),
    .in_value      (in_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_count_sum (out_count_sum)
  );

endmodule

@@ test/prime_factor_count_range_query_tb.sv @@
module prime_factor_count_range_query_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfc_pkg::*;

  // Command code 3 has no enum member; the block drops it.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // The limit covers the slowest correct run: reset clear, two builds, one
  // full-table query and the remaining short beats, with a wide margin.
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  // Long enough for the longest add, with all its factor steps, to finish.
  localparam int unsigned DRAIN_CYCLES = 500;
  // The last beats go out back to back.
  localparam int unsigned TAIL_BEATS   = 60;
  localparam int unsigned RANDOM_BEATS = 500;

  typedef struct {
    logic [1:0]         cmd;
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
  } pfc_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_cmd = CMD_BUILD;
  logic [FIELD_W-1:0] in_value = '0;
  logic [FIELD_W-1:0] in_range_low = '0;
  logic [FIELD_W-1:0] in_range_high = '0;
  logic out_valid;
  logic [SUM_W-1:0] out_count_sum;

  prime_factor_count_range_query u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_count_sum (out_count_sum)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: smallest-prime-factor table, per-prime tallies
  // and the built flag. Updated at the edge that accepts each beat.
  // ---------------------------------------------------------------------
  logic [FIELD_W-1:0] least_factor [TABLE_SIZE];
  logic [CNT_W-1:0]   prime_tally  [TABLE_SIZE];
  bit                 table_ready = 1'b0;

  pfc_beat_t        beat_q [$];        // beats not yet driven
  logic [SUM_W-1:0] pending_sums [$];  // query answers still owed by the block
  int unsigned      err_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      idle_left = 0;

  initial begin
    for (int unsigned k = 0; k < TABLE_SIZE; k++) prime_tally[k] = '0;
  end

  // Sieve as the block runs it: evens first, then odd primes up to sqrt.
  function automatic void sieve_rebuild();
    int unsigned i;
    int unsigned j;
    least_factor[0] = '0;
    least_factor[1] = 16'd1;
    for (i = 2; i < TABLE_SIZE; i++) least_factor[i] = i[FIELD_W-1:0];
    for (i = 4; i < TABLE_SIZE; i += 2) least_factor[i] = 16'd2;
    for (i = 3; i * i < TABLE_SIZE; i++) begin
      if (least_factor[i] == i[FIELD_W-1:0]) begin
        for (j = i * i; j < TABLE_SIZE; j += i)
          if (least_factor[j] == j[FIELD_W-1:0]) least_factor[j] = i[FIELD_W-1:0];
      end
    end
    for (i = 0; i < TABLE_SIZE; i++) prime_tally[i] = '0;
    table_ready = 1'b1;
  endfunction

  // Bump each distinct prime factor once, saturating.
  function automatic void tally_factors(logic [FIELD_W-1:0] v);
    int unsigned x;
    int unsigned p;
    int unsigned last;
    x = 32'(v);
    last = 0;
    if (!table_ready || x < 2 || x >= TABLE_SIZE) return;
    while (x >= 2) begin
      p = 32'(least_factor[x]);
      if (p < 2) break;
      if (p != last) begin
        if (prime_tally[p] != COUNT_MAX) prime_tally[p] = prime_tally[p] + CNT_W'(1);
        last = p;
      end
      x = x / p;
    end
  endfunction

  // Sum of tallies over [lo, hi], hi clamped to the table, 40-bit saturating.
  function automatic logic [SUM_W-1:0] range_total(logic [FIELD_W-1:0] lo,
                                                    logic [FIELD_W-1:0] hi);
    int unsigned top;
    longint unsigned acc;
    top = 32'(hi);
    acc = 0;
    if (top > TABLE_SIZE - 1) top = TABLE_SIZE - 1;
    if (32'(lo) > top) return '0;
    for (int unsigned i = 32'(lo); i <= top; i++) begin
      acc += 64'(prime_tally[i]);
      if (acc > 64'(SUM_MAX)) return SUM_MAX;
    end
    return acc[SUM_W-1:0];
  endfunction

  // Fold one accepted beat into the shadow; queries owe one answer.
  task automatic apply_beat(logic [1:0] cmd, logic [FIELD_W-1:0] v,
                            logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
    if (cmd == CMD_BUILD) sieve_rebuild();
    else if (cmd == CMD_ADD) tally_factors(v);
    else if (cmd == CMD_QUERY) pending_sums.push_back(range_total(lo, hi));
  endtask

  task automatic report_mismatch(string what, logic [SUM_W-1:0] got,
                                 logic [SUM_W-1:0] want);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic pfc_beat_t make_beat(logic [1:0] cmd, logic [FIELD_W-1:0] v,
                                          logic [FIELD_W-1:0] lo,
                                          logic [FIELD_W-1:0] hi);
    pfc_beat_t b;
    b.cmd = cmd;
    b.value = v;
    b.lo = lo;
    b.hi = hi;
    return b;
  endfunction

  // Random field value; also the filler for a field the beat does not use.
  function automatic logic [FIELD_W-1:0] noise();
    return FIELD_W'($urandom);
  endfunction

  // Random beat: mostly adds and short-span queries (long spans cost
  // one read per entry), a few spare-code beats. Unused fields carry noise.
  function automatic pfc_beat_t random_beat();
    pfc_beat_t b;
    int unsigned pick;
    int unsigned lo;
    int unsigned top;
    b.cmd = CMD_ADD;
    b.value = noise();
    b.lo = noise();
    b.hi = noise();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: b.value = noise();
        4, 5, 6:    b.value = FIELD_W'($urandom_range(2, 1000));
        7:          b.value = 16'd1 << $urandom_range(0, 15);
        8:          b.value = FIELD_W'($urandom_range(0, 1));
        default:    b.value = FIELD_W'(16'hFFFF - $urandom_range(0, 15));
      endcase
    end else if (pick < 95) begin
      b.cmd = CMD_QUERY;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // dense region: most counted primes are small
          lo = $urandom_range(0, 200);
          top = lo + $urandom_range(0, 64);
        end
        4, 5, 6, 7: begin
          lo = $urandom_range(0, TABLE_SIZE - 1);
          top = lo + $urandom_range(0, 64);
        end
        8: begin
          // empty range, low above high
          lo = $urandom_range(1, TABLE_SIZE - 1);
          top = lo - $urandom_range(1, lo);
        end
        default: begin
          lo = $urandom_range(0, TABLE_SIZE - 1);
          top = lo;
        end
      endcase
      if (top > TABLE_SIZE - 1) top = TABLE_SIZE - 1;
      b.lo = lo[FIELD_W-1:0];
      b.hi = top[FIELD_W-1:0];
    end else begin
      b.cmd = CMD_SPARE;
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: a beat is taken at an edge where start is high and busy low.
  // Inputs change only at rising edges, nonblocking. After each beat an
  // optional idle burst of free cycles (counted only while the block
  // is not busy), none in the tail of the run.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) apply_beat(in_cmd, in_value, in_range_low, in_range_high);
      if (!start || !busy) begin
        if (idle_left > 0) begin
          start <= 1'b0;
          if (!busy) idle_left <= idle_left - 1;
        end else if (beat_q.size() > 0) begin
          in_cmd        <= beat_q[0].cmd;
          in_value      <= beat_q[0].value;
          in_range_low  <= beat_q[0].lo;
          in_range_high <= beat_q[0].hi;
          start         <= 1'b1;
          beat_q.pop_front();
          if (beat_q.size() >= TAIL_BEATS && $urandom_range(0, 2) == 0)
            idle_left <= $urandom_range(1, 4);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest owed answer.
  always @(posedge clk) begin : monitor
    logic [SUM_W-1:0] want;
    if (rst_n && out_valid) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("result with nothing owed", out_count_sum, '0);
      end else begin
        want = pending_sums.pop_front();
        if (out_count_sum !== want) report_mismatch("count_sum", out_count_sum, want);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("prime_factor_count_range_query_tb: errors");
      $finish;
    end
  end

  initial begin
    // Directed: before the first build, then the table extremes.
    beat_q.push_back(make_beat(CMD_QUERY, noise(), 16'd0, 16'd300));
    beat_q.push_back(make_beat(CMD_ADD, 16'd12, noise(), noise()));  // dropped, no table
    beat_q.push_back(make_beat(CMD_QUERY, noise(), 16'd0, 16'd20));
    beat_q.push_back(make_beat(CMD_SPARE, noise(), noise(), noise()));
    beat_q.push_back(make_beat(CMD_BUILD, noise(), noise(), noise()));
    beat_q.push_back(make_beat(CMD_ADD, 16'd0, noise(), noise()));
    beat_q.push_back(make_beat(CMD_ADD, 16'd1, noise(), noise()));
    beat_q.push_back(make_beat(CMD_ADD, 16'd65535, noise(), noise()));  // 3*5*17*257
    beat_q.push_back(make_beat(CMD_ADD, 16'd65534, noise(), noise()));  // 2*7*31*151
    beat_q.push_back(make_beat(CMD_ADD, 16'd2, noise(), noise()));
    beat_q.push_back(make_beat(CMD_ADD, 16'd4, noise(), noise()));      // 2 counted once
    beat_q.push_back(make_beat(CMD_ADD, 16'd32768, noise(), noise()));  // 2^15
    beat_q.push_back(make_beat(CMD_ADD, 16'd65521, noise(), noise()));  // largest prime
    beat_q.push_back(make_beat(CMD_ADD, 16'd30030, noise(), noise()));
    beat_q.push_back(make_beat(CMD_ADD, 16'd12, noise(), noise()));
    beat_q.push_back(make_beat(CMD_QUERY, noise(), 16'd2, 16'd2));
    beat_q.push_back(make_beat(CMD_QUERY, noise(), 16'd0, 16'd65535));   // whole table
    beat_q.push_back(make_beat(CMD_QUERY, noise(), 16'd65535, 16'd0));   // low above high
    beat_q.push_back(make_beat(CMD_QUERY, noise(), 16'd65521, 16'd65535));
    beat_q.push_back(make_beat(CMD_QUERY, noise(), 16'd0, 16'd1));
    beat_q.push_back(make_beat(CMD_QUERY, noise(), 16'd257, 16'd257));
    beat_q.push_back(make_beat(CMD_SPARE, noise(), noise(), noise()));

    // Random part, with one rebuild halfway that must wipe the tallies.
    for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 2)
        beat_q.push_back(make_beat(CMD_BUILD, noise(), noise(), noise()));
      beat_q.push_back(random_beat());
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // All beats taken, all answers in, then let a trailing add finish.
    while (beat_q.size() > 0 || start || pending_sums.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) $display("prime_factor_count_range_query_tb: clean");
    else $display("prime_factor_count_range_query_tb: errors");
    $finish;
  end

endmodule

@@ prime_factor_count_range_query.f @@
sv/pfc_pkg.sv
sv/pfc_div.sv
sv/pfc_dp.sv
sv/pfc_ctrl.sv
sv/prime_factor_count_range_query.sv
test/prime_factor_count_range_query_tb.sv
